>>> sv/cdt_pkg.sv
package cdt_pkg;

  // Token kinds carried on the result channel.
  typedef enum logic [1:0] {
    KIND_OP   = 2'd0,
    KIND_INT  = 2'd1,
    KIND_REAL = 2'd2,
    KIND_ERR  = 2'd3
  } kind_t;

  // Token assembler state, one-hot.
  typedef enum logic [6:0] {
    FORM_IDLE = 7'b0000001,
    FORM_ESC  = 7'b0000010,
    FORM_POS  = 7'b0000100,
    FORM_NEG  = 7'b0001000,
    FORM_I16  = 7'b0010000,
    FORM_I32  = 7'b0100000,
    FORM_REAL = 7'b1000000
  } form_t;

  // Byte codes and operand constants of the dictionary encoding.
  localparam logic [7:0]  LAST_OP_BYTE  = 8'd21;
  localparam logic [7:0]  ESC_BYTE      = 8'd12;
  localparam logic [7:0]  I16_BYTE      = 8'd28;
  localparam logic [7:0]  I32_BYTE      = 8'd29;
  localparam logic [7:0]  REAL_BYTE     = 8'd30;
  localparam logic [7:0]  SMALL_LO      = 8'd32;
  localparam logic [7:0]  SMALL_HI      = 8'd246;
  localparam logic [7:0]  POS_LO        = 8'd247;
  localparam logic [7:0]  POS_HI        = 8'd250;
  localparam logic [7:0]  NEG_LO        = 8'd251;
  localparam logic [7:0]  NEG_HI        = 8'd254;
  localparam logic [31:0] SMALL_BIAS    = 32'd139;
  localparam logic [31:0] TWO_BYTE_BIAS = 32'd108;
  localparam logic [3:0]  REAL_TERM     = 4'hF;
  localparam logic [2:0]  I16_LEN       = 3'd2;
  localparam logic [2:0]  I32_LEN       = 3'd4;

  // One result token.
  typedef struct packed {
    kind_t              token_kind;
    logic [7:0]         operator_code;
    logic               escaped_operator;
    logic signed [31:0] int_value;
    logic [7:0]         real_byte;
    logic               real_end;
    logic               dict_end;
  } token_t;

endpackage

>>> sv/cdt_if.sv
// Byte channel into the tokenizer.
interface cdt_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// Token channel out of the tokenizer.
interface cdt_token_if;
  logic               valid;
  logic               ready;
  cdt_pkg::kind_t     token_kind;
  logic [7:0]         operator_code;
  logic               escaped_operator;
  logic signed [31:0] int_value;
  logic [7:0]         real_byte;
  logic               real_end;
  logic               dict_end;

  modport source (output valid, output token_kind, output operator_code,
                  output escaped_operator, output int_value, output real_byte,
                  output real_end, output dict_end, input ready);
  modport sink   (input valid, input token_kind, input operator_code,
                  input escaped_operator, input int_value, input real_byte,
                  input real_end, input dict_end, output ready);
endinterface

>>> sv/cff_dict_tokenizer_top.sv
// Font DICT tokenizer: takes one dictionary byte per cycle and emits at most
// one token (operator, integer operand, raw real-operand byte or format error)
// per byte. A byte is registered on entry, decoded combinationally against the
// small token assembler state, and its token is then registered in the output
// register. Bytes that only open a token (escape, multi-byte integer prefixes,
// the real marker) are consumed without a token. Throughput is one byte per
// cycle; the input side stalls only while the output register holds a token
// that the sink has not taken.
module cff_dict_tokenizer_top (
  input  logic        clk,
  input  logic        rst,
  cdt_byte_if.sink    byte_in,
  cdt_token_if.source token_out
);
  import cdt_pkg::*;

  logic       held_valid;
  logic [7:0] held_byte;
  logic       held_last;
  logic       space;
  logic       step;
  logic       have;
  token_t     token;

  // A held byte is consumed whenever the output register can take its token.
  assign step = held_valid && space;

  cdt_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .byte_in    (byte_in),
    .take       (step),
    .held_valid (held_valid),
    .held_byte  (held_byte),
    .held_last  (held_last)
  );

  cdt_decoder u_dec (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .data_byte (held_byte),
    .last_byte (held_last),
    .have      (have),
    .token     (token)
  );

  cdt_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (step && have),
    .token     (token),
    .space     (space),
    .token_out (token_out)
  );

endmodule

>>> sv/cdt_in_stage.sv
module cdt_in_stage (
  input  logic       clk,
  input  logic       rst,
  cdt_byte_if.sink   byte_in,
  input  logic       take,
  output logic       held_valid,
  output logic [7:0] held_byte,
  output logic       held_last
);
  import cdt_pkg::*;

  // The register accepts a new item when empty or when its item moves on.
  assign byte_in.ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (byte_in.ready) begin
      held_valid <= byte_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_in.valid && byte_in.ready) begin
      held_byte <= byte_in.data_byte;
      held_last <= byte_in.last_byte;
    end
  end

endmodule

>>> sv/cdt_decoder.sv
module cdt_decoder (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  output logic                have,
  output cdt_pkg::token_t     token
);
  import cdt_pkg::*;

  form_t       pending_form, pending_form_next;
  logic [2:0]  bytes_remaining, bytes_remaining_next;
  logic [31:0] value_accumulator, value_accumulator_next;
  logic [1:0]  lead_offset, lead_offset_next;

  logic [31:0] acc_shift;
  logic [2:0]  rem_dec;
  logic [31:0] two_byte_mag;
  logic [31:0] small_val;
  logic [7:0]  pos_off, neg_off;
  logic        term;

  // Shared arithmetic for the operand forms.
  always_comb begin
    acc_shift    = {value_accumulator[23:0], data_byte};
    rem_dec      = (bytes_remaining != 3'd0) ? bytes_remaining - 3'd1 : 3'd0;
    two_byte_mag = {22'd0, lead_offset, data_byte} + TWO_BYTE_BIAS;
    small_val    = {24'd0, data_byte} - SMALL_BIAS;
    pos_off      = data_byte - POS_LO;
    neg_off      = data_byte - NEG_LO;
    term         = (data_byte[7:4] == REAL_TERM) || (data_byte[3:0] == REAL_TERM);
  end

  // Next state and token for the current byte.
  always_comb begin
    have                   = 1'b0;
    token                  = '0;
    pending_form_next      = pending_form;
    bytes_remaining_next   = bytes_remaining;
    value_accumulator_next = value_accumulator;
    lead_offset_next       = lead_offset;

    case (pending_form)
      FORM_ESC: begin
        have                   = 1'b1;
        token.token_kind       = KIND_OP;
        token.operator_code    = data_byte;
        token.escaped_operator = 1'b1;
        pending_form_next      = FORM_IDLE;
      end
      FORM_POS: begin
        have              = 1'b1;
        token.token_kind  = KIND_INT;
        token.int_value   = $signed(two_byte_mag);
        pending_form_next = FORM_IDLE;
        lead_offset_next  = 2'd0;
      end
      FORM_NEG: begin
        have              = 1'b1;
        token.token_kind  = KIND_INT;
        token.int_value   = $signed(32'd0 - two_byte_mag);
        pending_form_next = FORM_IDLE;
        lead_offset_next  = 2'd0;
      end
      FORM_I16, FORM_I32: begin
        value_accumulator_next = acc_shift;
        bytes_remaining_next   = rem_dec;
        if (rem_dec == 3'd0) begin
          have             = 1'b1;
          token.token_kind = KIND_INT;
          if (pending_form == FORM_I16) begin
            token.int_value = $signed({{16{acc_shift[15]}}, acc_shift[15:0]});
          end else begin
            token.int_value = $signed(acc_shift);
          end
          pending_form_next      = FORM_IDLE;
          value_accumulator_next = 32'd0;
        end
      end
      FORM_REAL: begin
        have             = 1'b1;
        token.token_kind = KIND_REAL;
        token.real_byte  = data_byte;
        token.real_end   = term;
        if (term) begin
          pending_form_next = FORM_IDLE;
        end
      end
      default: begin
        // Start of a new token.
        pending_form_next      = FORM_IDLE;
        bytes_remaining_next   = 3'd0;
        value_accumulator_next = 32'd0;
        lead_offset_next       = 2'd0;
        if (data_byte <= LAST_OP_BYTE && data_byte != ESC_BYTE) begin
          have                = 1'b1;
          token.token_kind    = KIND_OP;
          token.operator_code = data_byte;
        end else if (data_byte == ESC_BYTE) begin
          pending_form_next = FORM_ESC;
        end else if (data_byte >= SMALL_LO && data_byte <= SMALL_HI) begin
          have             = 1'b1;
          token.token_kind = KIND_INT;
          token.int_value  = $signed(small_val);
        end else if (data_byte >= POS_LO && data_byte <= POS_HI) begin
          pending_form_next = FORM_POS;
          lead_offset_next  = pos_off[1:0];
        end else if (data_byte >= NEG_LO && data_byte <= NEG_HI) begin
          pending_form_next = FORM_NEG;
          lead_offset_next  = neg_off[1:0];
        end else if (data_byte == I16_BYTE) begin
          pending_form_next    = FORM_I16;
          bytes_remaining_next = I16_LEN;
        end else if (data_byte == I32_BYTE) begin
          pending_form_next    = FORM_I32;
          bytes_remaining_next = I32_LEN;
        end else if (data_byte == REAL_BYTE) begin
          pending_form_next = FORM_REAL;
        end else begin
          have             = 1'b1;
          token.token_kind = KIND_ERR;
        end
      end
    endcase

    // The final byte of a dictionary closes any unfinished token as an error.
    if (last_byte) begin
      if (pending_form_next != FORM_IDLE) begin
        have                   = 1'b1;
        token                  = '0;
        token.token_kind       = KIND_ERR;
        pending_form_next      = FORM_IDLE;
        bytes_remaining_next   = 3'd0;
        value_accumulator_next = 32'd0;
        lead_offset_next       = 2'd0;
      end
      token.dict_end = 1'b1;
    end
  end

  // Assembler state advances once per consumed byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_form      <= FORM_IDLE;
      bytes_remaining   <= 3'd0;
      value_accumulator <= 32'd0;
      lead_offset       <= 2'd0;
    end else if (step) begin
      pending_form      <= pending_form_next;
      bytes_remaining   <= bytes_remaining_next;
      value_accumulator <= value_accumulator_next;
      lead_offset       <= lead_offset_next;
    end
  end

endmodule

>>> sv/cdt_out_stage.sv
module cdt_out_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  cdt_pkg::token_t token,
  output logic            space,
  cdt_token_if.source     token_out
);
  import cdt_pkg::*;

  logic   out_valid;
  token_t out_token;

  // A new token may enter when the register is empty or is being drained.
  assign space = !out_valid || token_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (space) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (space && load) begin
      out_token <= token;
    end
  end

  // Drive the result channel from the register.
  assign token_out.valid            = out_valid;
  assign token_out.token_kind       = out_token.token_kind;
  assign token_out.operator_code    = out_token.operator_code;
  assign token_out.escaped_operator = out_token.escaped_operator;
  assign token_out.int_value        = out_token.int_value;
  assign token_out.real_byte        = out_token.real_byte;
  assign token_out.real_end         = out_token.real_end;
  assign token_out.dict_end         = out_token.dict_end;

endmodule
